>>> sv/ksv_pkg.sv
// ksv_pkg: shared types, register codes and constants of the key velocity sensor
// no dependencies; used by ksv_divider, ksv_seq and key_strike_velocity_sensor_top
package ksv_pkg;

	// configuration register indexes
	localparam logic [2:0] CFG_PRESS_LO  = 3'd0;
	localparam logic [2:0] CFG_PRESS_HI  = 3'd1;
	localparam logic [2:0] CFG_BOTTOM_LO = 3'd2;
	localparam logic [2:0] CFG_BOTTOM_HI = 3'd3;
	localparam logic [2:0] CFG_MIN_SPEED = 3'd4;
	localparam logic [2:0] CFG_MAX_SPEED = 3'd5;
	localparam logic [2:0] CFG_TRAVEL    = 3'd6;

	// register reset values
	localparam logic [31:0] MIN_SPEED_RST = 32'd1000;
	localparam logic [31:0] MAX_SPEED_RST = 32'd9500;
	localparam logic [7:0]  TRAVEL_RST    = 8'd40;

	// speed numerator scale and divider widths
	localparam logic [27:0] SPEED_SCALE = 28'd1000000;
	localparam int DIV_REM_W  = 32;
	localparam int DIV_BITS_W = 28;
	localparam int DIV_CNT_W  = 5;
	localparam logic [DIV_CNT_W-1:0] SPEED_STEPS = 5'd28;
	localparam logic [DIV_CNT_W-1:0] MAP_STEPS   = 5'd7;

	// velocity curve
	localparam logic [7:0] CURVE_LOW_MAX = 8'd60;
	localparam logic [7:0] CURVE_MID_MIN = 8'd61;
	localparam logic [7:0] CURVE_MID_MAX = 8'd85;
	localparam logic [7:0] CURVE_LOW_ADD = 8'd40;
	localparam logic [7:0] CURVE_MID_ADD = 8'd10;
	localparam logic [7:0] VEL_MAX       = 8'd127;

	typedef struct packed {
		logic [63:0] press_lo;
		logic [31:0] press_hi;
		logic [63:0] bottom_lo;
		logic [31:0] bottom_hi;
		logic [31:0] min_speed;
		logic [31:0] max_speed;
		logic [7:0]  travel;
	} cfg_t;

	typedef struct packed {
		logic                  start;
		logic [DIV_REM_W-1:0]  rem_init;
		logic [DIV_BITS_W-1:0] bits;
		logic [DIV_REM_W-1:0]  den;
		logic [DIV_CNT_W-1:0]  steps;
	} div_req_t;

	typedef struct packed {
		logic                  busy;
		logic [DIV_BITS_W-1:0] quotient;
	} div_rsp_t;

	// threshold byte of one key from a low/high register pair
	function automatic logic [7:0] level_of(input logic [63:0] lo, input logic [31:0] hi,
		input logic [3:0] key);
		logic [7:0] lvl;
		if (!key[3]) begin
			lvl = lo[{key[2:0], 3'b000} +: 8];
		end else begin
			lvl = hi[{key[1:0], 3'b000} +: 8];
		end
		return lvl;
	endfunction

endpackage

>>> sv/ksv_divider.sv
// ksv_divider: shared restoring divider, one quotient bit per cycle
// depends on ksv_pkg (div_req_t, div_rsp_t, widths)
module ksv_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  ksv_pkg::div_req_t req,
	output ksv_pkg::div_rsp_t rsp
);

	logic                           busy_q;
	logic [ksv_pkg::DIV_CNT_W-1:0]  cnt_q;
	logic [ksv_pkg::DIV_REM_W-1:0]  rem_q;
	logic [ksv_pkg::DIV_BITS_W-1:0] sh_q;
	logic [ksv_pkg::DIV_REM_W-1:0]  den_q;
	logic [ksv_pkg::DIV_REM_W:0]    trial;
	logic [ksv_pkg::DIV_REM_W:0]    diff;
	logic                           ge;

	// trial subtract of the next partial remainder
	assign trial = {rem_q, sh_q[ksv_pkg::DIV_BITS_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= req.steps;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == ksv_pkg::DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// remainder and dividend/quotient shift register
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.rem_init;
			sh_q  <= req.bits;
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[ksv_pkg::DIV_REM_W-1:0] : trial[ksv_pkg::DIV_REM_W-1:0];
			sh_q  <= {sh_q[ksv_pkg::DIV_BITS_W-2:0], ge};
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.quotient = sh_q;

endmodule

>>> sv/ksv_seq.sv
// ksv_seq: per-key state, sequencer over the shared divider, result register
// depends on ksv_pkg and ksv_divider
module ksv_seq #(
	parameter int NUM_KEYS = 12
) (
	input  logic          clk,
	input  logic          arst_n,
	input  ksv_pkg::cfg_t cfg,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [3:0]    key_index,
	input  logic [7:0]    sample,
	input  logic [15:0]   timestamp,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [3:0]    key_id,
	output logic          is_down,
	output logic          strike,
	output logic [6:0]    velocity,
	output logic [27:0]   raw_speed
);

	localparam int KEY_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_LOOK  = 3'd1;
	localparam logic [2:0] S_DIV1  = 3'd2;
	localparam logic [2:0] S_CLAMP = 3'd3;
	localparam logic [2:0] S_MUL   = 3'd4;
	localparam logic [2:0] S_DIV2  = 3'd5;
	localparam logic [2:0] S_CURVE = 3'd6;
	localparam logic [2:0] S_DONE  = 3'd7;

	logic [2:0]  state_q;
	logic [3:0]  key_q;
	logic [7:0]  sample_q;
	logic [15:0] ts_q;
	logic        inr_q;
	logic        down_q;
	logic        strike_q;
	logic        empty_q;
	logic [27:0] speed_q;
	logic [31:0] diff_q;
	logic        out_valid_q;
	logic [3:0]  key_id_q;
	logic        is_down_q;
	logic        strike_out_q;
	logic [6:0]  velocity_q;
	logic [27:0] raw_speed_q;

	// per-key state
	logic        down_arr_q   [NUM_KEYS];
	logic        bott_arr_q   [NUM_KEYS];
	logic [15:0] press_arr_q  [NUM_KEYS];
	logic [6:0]  vel_arr_q    [NUM_KEYS];
	logic [27:0] spd_arr_q    [NUM_KEYS];

	logic [KEY_W-1:0]  idx;
	logic              in_range;
	logic              down_c;
	logic              was_down;
	logic              bot_c;
	logic [15:0]       elapsed;
	logic              go_div;
	logic [31:0]       speed32;
	logic [31:0]       clamped;
	logic [38:0]       prod;
	logic [6:0]        s_raw;
	logic [7:0]        s_curved;
	logic [6:0]        vel_c;
	logic              load_out;

	ksv_pkg::div_req_t div_req;
	ksv_pkg::div_rsp_t div_rsp;

	ksv_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign idx      = key_q[KEY_W-1:0];
	assign in_range = {1'b0, key_q} < 5'(NUM_KEYS);

	// threshold compares and elapsed ticks
	assign down_c   = sample_q < ksv_pkg::level_of(cfg.press_lo, cfg.press_hi, key_q);
	assign bot_c    = sample_q < ksv_pkg::level_of(cfg.bottom_lo, cfg.bottom_hi, key_q);
	assign was_down = down_arr_q[idx];
	assign elapsed  = ts_q - press_arr_q[idx];
	assign go_div   = in_range && down_c && was_down && bot_c && !bott_arr_q[idx]
		&& (elapsed != 16'd0);

	// clamp and scale by 126 as (x << 7) - (x << 1)
	assign speed32 = {4'b0000, speed_q};
	always_comb begin
		if (speed32 <= cfg.min_speed) begin
			clamped = cfg.min_speed;
		end else if (speed32 >= cfg.max_speed) begin
			clamped = cfg.max_speed;
		end else begin
			clamped = speed32;
		end
	end
	assign prod = {diff_q, 7'b0000000} - {6'b000000, diff_q, 1'b0};

	// velocity curve
	assign s_raw = div_rsp.quotient[6:0];
	always_comb begin
		if ({1'b0, s_raw} <= ksv_pkg::CURVE_LOW_MAX) begin
			s_curved = {1'b0, s_raw} + ksv_pkg::CURVE_LOW_ADD;
		end else if ({1'b0, s_raw} inside {[ksv_pkg::CURVE_MID_MIN:ksv_pkg::CURVE_MID_MAX]}) begin
			s_curved = {1'b0, s_raw} + ksv_pkg::CURVE_MID_ADD;
		end else begin
			s_curved = {1'b0, s_raw};
		end
		vel_c = (s_curved > ksv_pkg::VEL_MAX) ? ksv_pkg::VEL_MAX[6:0] : s_curved[6:0];
	end

	// divider requests: speed division, then mapping division
	always_comb begin
		div_req = '0;
		if (state_q == S_LOOK && go_div) begin
			div_req.start    = 1'b1;
			div_req.rem_init = '0;
			div_req.bits     = {20'd0, cfg.travel} * ksv_pkg::SPEED_SCALE;
			div_req.den      = {16'd0, elapsed};
			div_req.steps    = ksv_pkg::SPEED_STEPS;
		end else if (state_q == S_MUL && !empty_q) begin
			div_req.start    = 1'b1;
			div_req.rem_init = prod[38:7];
			div_req.bits     = {prod[6:0], 21'd0};
			div_req.den      = cfg.max_speed - cfg.min_speed;
			div_req.steps    = ksv_pkg::MAP_STEPS;
		end
	end

	assign in_ready = (state_q == S_IDLE);
	assign load_out = (state_q == S_DONE) && (!out_valid_q || out_ready);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			inr_q    <= 1'b0;
			down_q   <= 1'b0;
			strike_q <= 1'b0;
			empty_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					inr_q    <= in_range;
					down_q   <= in_range && down_c;
					strike_q <= 1'b0;
					state_q  <= go_div ? S_DIV1 : S_DONE;
				end
				S_DIV1: begin
					if (!div_rsp.busy) begin
						state_q <= S_CLAMP;
					end
				end
				S_CLAMP: begin
					empty_q <= cfg.max_speed <= cfg.min_speed;
					state_q <= S_MUL;
				end
				S_MUL: begin
					state_q <= empty_q ? S_CURVE : S_DIV2;
				end
				S_DIV2: begin
					if (!div_rsp.busy) begin
						state_q <= S_CURVE;
					end
				end
				S_CURVE: begin
					strike_q <= 1'b1;
					state_q  <= S_DONE;
				end
				S_DONE: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// item payload and intermediate values
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			key_q    <= key_index;
			sample_q <= sample;
			ts_q     <= timestamp;
		end
		if (state_q == S_DIV1 && !div_rsp.busy) begin
			speed_q <= div_rsp.quotient;
		end
		if (state_q == S_CLAMP) begin
			diff_q <= clamped - cfg.min_speed;
		end
	end

	// per-key state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_KEYS; k++) begin
				down_arr_q[k]  <= 1'b0;
				bott_arr_q[k]  <= 1'b0;
				press_arr_q[k] <= '0;
				vel_arr_q[k]   <= '0;
				spd_arr_q[k]   <= '0;
			end
		end else begin
			if (state_q == S_LOOK && in_range) begin
				down_arr_q[idx] <= down_c;
				if (!down_c) begin
					bott_arr_q[idx]  <= 1'b0;
					press_arr_q[idx] <= '0;
					vel_arr_q[idx]   <= '0;
					spd_arr_q[idx]   <= '0;
				end else if (!was_down) begin
					press_arr_q[idx] <= ts_q;
				end else if (bot_c && !bott_arr_q[idx]) begin
					bott_arr_q[idx] <= 1'b1;
				end
			end
			if (state_q == S_CURVE) begin
				spd_arr_q[idx] <= speed_q;
				vel_arr_q[idx] <= empty_q ? 7'd0 : vel_c;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			key_id_q     <= key_q;
			is_down_q    <= down_q;
			strike_out_q <= strike_q;
			velocity_q   <= inr_q ? vel_arr_q[idx] : 7'd0;
			raw_speed_q  <= inr_q ? spd_arr_q[idx] : 28'd0;
		end
	end

	assign out_valid = out_valid_q;
	assign key_id    = key_id_q;
	assign is_down   = is_down_q;
	assign strike    = strike_out_q;
	assign velocity  = velocity_q;
	assign raw_speed = raw_speed_q;

	// a strike is only reported for a key that is down
	a_strike_down: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && strike_out_q |-> is_down_q)
		else $error("strike reported for a released key");

	// a key outside the key range gives a transaction whose result fields are all zero
	a_out_of_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && ({1'b0, key_id_q} >= 5'(NUM_KEYS))
		|-> !is_down_q && !strike_out_q && velocity_q == 7'd0 && raw_speed_q == 28'd0)
		else $error("out of range key produced nonzero result");

	// the speed division actually starts
	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LOOK) && div_req.start |=> div_rsp.busy)
		else $error("divider did not start");

	// velocity is written only after the divider finished
	a_curve_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CURVE) |-> !div_rsp.busy)
		else $error("curve stage reached with divider busy");

endmodule

>>> sv/key_strike_velocity_sensor_top.sv
// key_strike_velocity_sensor_top: configuration registers and the key sequencer
// depends on ksv_pkg and ksv_seq (which uses ksv_divider)
// a transaction goes through the lookup and done states to the result register; a strike
// also passes the 28-step speed division, clamp, scale, 7-step mapping division (skipped
// when the speed range is empty) and curve, both divisions in the one shared shift-subtract
// divider; a new sample is taken only in idle, after the last result is loaded, which waits on out_ready
// reset: clears all key state and loads register defaults; no clearing pass
module key_strike_velocity_sensor_top #(
	parameter int NUM_KEYS = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [3:0]  key_index,
	input  logic [7:0]  sample,
	input  logic [15:0] timestamp,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  key_id,
	output logic        is_down,
	output logic        strike,
	output logic [6:0]  velocity,
	output logic [27:0] raw_speed
);

	ksv_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;

	// configuration register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.press_lo  <= '0;
			cfg_q.press_hi  <= '0;
			cfg_q.bottom_lo <= '0;
			cfg_q.bottom_hi <= '0;
			cfg_q.min_speed <= ksv_pkg::MIN_SPEED_RST;
			cfg_q.max_speed <= ksv_pkg::MAX_SPEED_RST;
			cfg_q.travel    <= ksv_pkg::TRAVEL_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				ksv_pkg::CFG_PRESS_LO:  cfg_q.press_lo  <= cfg_data;
				ksv_pkg::CFG_PRESS_HI:  cfg_q.press_hi  <= cfg_data[31:0];
				ksv_pkg::CFG_BOTTOM_LO: cfg_q.bottom_lo <= cfg_data;
				ksv_pkg::CFG_BOTTOM_HI: cfg_q.bottom_hi <= cfg_data[31:0];
				ksv_pkg::CFG_MIN_SPEED: cfg_q.min_speed <= cfg_data[31:0];
				ksv_pkg::CFG_MAX_SPEED: cfg_q.max_speed <= cfg_data[31:0];
				ksv_pkg::CFG_TRAVEL:    cfg_q.travel    <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	ksv_seq #(
		.NUM_KEYS (NUM_KEYS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.key_index (key_index),
		.sample    (sample),
		.timestamp (timestamp),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.key_id    (key_id),
		.is_down   (is_down),
		.strike    (strike),
		.velocity  (velocity),
		.raw_speed (raw_speed)
	);

endmodule
